/* design/sgr_pkg.sv */
// Shared types, constants and font table for the scaled glyph row renderer.
`timescale 1ns / 1ps

package sgr_pkg;

    localparam int          FONT_ROWS  = 7;
    localparam int          GLYPH_COLS = 5;
    localparam int          MASK_W     = 15;
    localparam logic [1:0]  MAX_SCALE  = 2'd3;
    localparam logic [2:0]  ROW_LAST   = 3'(FONT_ROWS - 1);

    // configuration register indexes
    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_LINE_BYTES    = 3'd2;
    localparam logic [2:0] CFG_BYTES_PER_PIX = 3'd3;
    localparam logic [2:0] CFG_FRAME_BASE    = 3'd4;

    // reset values
    localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd1280;
    localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd720;
    localparam logic [15:0] RST_LINE_BYTES    = 16'd5120;
    localparam logic [2:0]  RST_BYTES_PER_PIX = 3'd4;
    localparam logic [31:0] RST_FRAME_BASE    = 32'd0;

    // glyph: row 0 is the top row, bit 4 of a row is the leftmost dot
    typedef logic [FONT_ROWS-1:0][GLYPH_COLS-1:0] t_glyph;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PROD = 4'b0010,
        S_SUM  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;   // capture item
        logic prod;   // register products and column clip
        logic sum;    // register first row address
        logic emit;   // load one row into the output register
    } t_cmd;

    typedef struct packed {
        logic out_free;  // output register empty or being drained
        logic row_last;  // next row to emit is the character's last
    } t_sts;

    function automatic t_glyph mk_glyph(logic [4:0] r0, logic [4:0] r1, logic [4:0] r2,
                                        logic [4:0] r3, logic [4:0] r4, logic [4:0] r5,
                                        logic [4:0] r6);
        mk_glyph = {r6, r5, r4, r3, r2, r1, r0};
    endfunction

    function automatic t_glyph font_lookup(logic [7:0] code_in);
        logic [7:0] c;
        t_glyph     g;
        c = code_in;
        if (c >= 8'h61 && c <= 8'h7A) begin
            c = c - 8'h20;
        end
        case (c)
            8'h20: g = mk_glyph(0, 0, 0, 0, 0, 0, 0);
            8'h2D: g = mk_glyph(0, 0, 0, 31, 0, 0, 0);
            8'h2E: g = mk_glyph(0, 0, 0, 0, 0, 12, 12);
            8'h3A: g = mk_glyph(0, 12, 12, 0, 12, 12, 0);
            8'h2F: g = mk_glyph(1, 2, 4, 8, 16, 0, 0);
            8'h5B: g = mk_glyph(14, 8, 8, 8, 8, 8, 14);
            8'h5D: g = mk_glyph(14, 2, 2, 2, 2, 2, 14);
            8'h30: g = mk_glyph(14, 17, 19, 21, 25, 17, 14);
            8'h31: g = mk_glyph(4, 12, 4, 4, 4, 4, 14);
            8'h32: g = mk_glyph(14, 17, 1, 2, 4, 8, 31);
            8'h33: g = mk_glyph(30, 1, 1, 14, 1, 1, 30);
            8'h34: g = mk_glyph(2, 6, 10, 18, 31, 2, 2);
            8'h35: g = mk_glyph(31, 16, 16, 30, 1, 1, 30);
            8'h36: g = mk_glyph(14, 16, 16, 30, 17, 17, 14);
            8'h37: g = mk_glyph(31, 1, 2, 4, 8, 8, 8);
            8'h38: g = mk_glyph(14, 17, 17, 14, 17, 17, 14);
            8'h39: g = mk_glyph(14, 17, 17, 15, 1, 1, 14);
            8'h41: g = mk_glyph(14, 17, 17, 31, 17, 17, 17);
            8'h42: g = mk_glyph(30, 17, 17, 30, 17, 17, 30);
            8'h43: g = mk_glyph(14, 17, 16, 16, 16, 17, 14);
            8'h44: g = mk_glyph(28, 18, 17, 17, 17, 18, 28);
            8'h45: g = mk_glyph(31, 16, 16, 30, 16, 16, 31);
            8'h46: g = mk_glyph(31, 16, 16, 30, 16, 16, 16);
            8'h47: g = mk_glyph(14, 17, 16, 23, 17, 17, 15);
            8'h48: g = mk_glyph(17, 17, 17, 31, 17, 17, 17);
            8'h49: g = mk_glyph(14, 4, 4, 4, 4, 4, 14);
            8'h4A: g = mk_glyph(7, 2, 2, 2, 18, 18, 12);
            8'h4B: g = mk_glyph(17, 18, 20, 24, 20, 18, 17);
            8'h4C: g = mk_glyph(16, 16, 16, 16, 16, 16, 31);
            8'h4D: g = mk_glyph(17, 27, 21, 21, 17, 17, 17);
            8'h4E: g = mk_glyph(17, 25, 21, 19, 17, 17, 17);
            8'h4F: g = mk_glyph(14, 17, 17, 17, 17, 17, 14);
            8'h50: g = mk_glyph(30, 17, 17, 30, 16, 16, 16);
            8'h51: g = mk_glyph(14, 17, 17, 17, 21, 18, 13);
            8'h52: g = mk_glyph(30, 17, 17, 30, 20, 18, 17);
            8'h53: g = mk_glyph(15, 16, 16, 14, 1, 1, 30);
            8'h54: g = mk_glyph(31, 4, 4, 4, 4, 4, 4);
            8'h55: g = mk_glyph(17, 17, 17, 17, 17, 17, 14);
            8'h56: g = mk_glyph(17, 17, 17, 17, 17, 10, 4);
            8'h57: g = mk_glyph(17, 17, 17, 21, 21, 21, 10);
            8'h58: g = mk_glyph(17, 17, 10, 4, 10, 17, 17);
            8'h59: g = mk_glyph(17, 17, 10, 4, 4, 4, 4);
            8'h5A: g = mk_glyph(31, 1, 2, 4, 8, 16, 31);
            default: g = mk_glyph(31, 1, 2, 4, 0, 4, 0);  // unknown glyph
        endcase
        return g;
    endfunction

    // widen one glyph row: each dot repeats scale times, leftmost dot at bit 0
    function automatic logic [MASK_W-1:0] expand_row(logic [4:0] dots, logic [1:0] scale);
        logic [MASK_W-1:0] m;
        m = '0;
        case (scale)
            2'd1: for (int i = 0; i < GLYPH_COLS; i++) m[i] = dots[4 - i];
            2'd2: for (int i = 0; i < 2 * GLYPH_COLS; i++) m[i] = dots[4 - i / 2];
            2'd3: for (int i = 0; i < 3 * GLYPH_COLS; i++) m[i] = dots[4 - i / 3];
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

/* design/sgr_ctrl.sv */
// Sequencer for the glyph renderer: item capture, setup steps, row emission.
`timescale 1ns / 1ps

module sgr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_scale,
    output logic          o_in_ready,
    input  sgr_pkg::t_sts i_sts,
    output sgr_pkg::t_cmd o_cmd
);

    sgr_pkg::t_state r_state, n_state;
    logic            w_accept;

    assign o_in_ready = (r_state == sgr_pkg::S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = w_accept;
        o_cmd.prod = (r_state == sgr_pkg::S_PROD);
        o_cmd.sum  = (r_state == sgr_pkg::S_SUM);
        o_cmd.emit = (r_state == sgr_pkg::S_EMIT) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sgr_pkg::S_IDLE: begin
                // a zero scale item produces nothing
                if (w_accept && i_scale != 2'd0) n_state = sgr_pkg::S_PROD;
            end
            sgr_pkg::S_PROD: n_state = sgr_pkg::S_SUM;
            sgr_pkg::S_SUM:  n_state = sgr_pkg::S_EMIT;
            sgr_pkg::S_EMIT: begin
                if (i_sts.out_free && i_sts.row_last) n_state = sgr_pkg::S_IDLE;
            end
            default: n_state = sgr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sgr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("row emitted into an occupied output register");

    a_last_row_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_sts.row_last) |=> o_in_ready)
        else $error("not idle after last row");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_scale != 2'd0) |=> (!o_in_ready && !o_cmd.emit))
        else $error("item accepted but setup did not start");
`endif

endmodule

/* design/sgr_dp.sv */
// Datapath: config registers, glyph lookup, address arithmetic, row output register.
`timescale 1ns / 1ps

module sgr_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sgr_pkg::t_cmd i_cmd,
    output sgr_pkg::t_sts o_sts,
    input  logic          i_cfg_valid,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    input  logic [7:0]    i_char_code,
    input  logic [11:0]   i_start_x,
    input  logic [11:0]   i_start_y,
    input  logic [1:0]    i_scale,
    input  logic [31:0]   i_pixel_value,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [31:0]   o_row_address,
    output logic [14:0]   o_pixel_mask,
    output logic [31:0]   o_color,
    output logic [2:0]    o_pixel_size,
    output logic          o_last_row
);

    // configuration
    logic [11:0] r_width, r_height;
    logic [15:0] r_line_bytes;
    logic [2:0]  r_bpp;
    logic [31:0] r_base;

    // item
    sgr_pkg::t_glyph r_glyph;
    logic [11:0] r_sx, r_sy;
    logic [1:0]  r_scale;
    logic [31:0] r_color;

    // working
    logic [27:0] r_prod_y;
    logic [14:0] r_prod_x;
    logic [14:0] r_vis;
    logic [31:0] r_addr;
    logic [12:0] r_line;
    logic [2:0]  r_grow;
    logic [1:0]  r_rep;

    // output register
    logic        r_out_valid;
    logic [31:0] r_out_addr;
    logic [14:0] r_out_mask;
    logic [31:0] r_out_color;
    logic [2:0]  r_out_size;
    logic        r_out_last;

    logic [14:0] w_vis;
    logic [14:0] w_mask;
    logic        w_row_on;
    logic        w_rep_end;

    assign w_rep_end      = (r_rep == r_scale - 2'd1);
    assign o_sts.row_last = (r_grow == sgr_pkg::ROW_LAST) && w_rep_end;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        for (int i = 0; i < sgr_pkg::MASK_W; i++) begin
            w_vis[i] = (({1'b0, r_sx} + 13'(i)) < {1'b0, r_width});
        end
    end

    assign w_row_on = (r_bpp >= 3'd2) && (r_bpp <= 3'd4) && (r_line < {1'b0, r_height});
    assign w_mask   = sgr_pkg::expand_row(r_glyph[r_grow], r_scale) & r_vis
                      & {sgr_pkg::MASK_W{w_row_on}};

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= sgr_pkg::RST_SCREEN_WIDTH;
            r_height     <= sgr_pkg::RST_SCREEN_HEIGHT;
            r_line_bytes <= sgr_pkg::RST_LINE_BYTES;
            r_bpp        <= sgr_pkg::RST_BYTES_PER_PIX;
            r_base       <= sgr_pkg::RST_FRAME_BASE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sgr_pkg::CFG_SCREEN_WIDTH:  r_width      <= i_cfg_data[11:0];
                sgr_pkg::CFG_SCREEN_HEIGHT: r_height     <= i_cfg_data[11:0];
                sgr_pkg::CFG_LINE_BYTES:    r_line_bytes <= i_cfg_data[15:0];
                sgr_pkg::CFG_BYTES_PER_PIX: r_bpp        <= i_cfg_data[2:0];
                sgr_pkg::CFG_FRAME_BASE:    r_base       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // item and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_glyph <= sgr_pkg::font_lookup(i_char_code);
            r_sx    <= i_start_x;
            r_sy    <= i_start_y;
            r_scale <= (i_scale > sgr_pkg::MAX_SCALE) ? sgr_pkg::MAX_SCALE : i_scale;
            r_color <= i_pixel_value;
        end
        if (i_cmd.prod) begin
            r_prod_y <= 28'(r_sy) * 28'(r_line_bytes);
            r_prod_x <= 15'(r_sx) * 15'(r_bpp);
            r_vis    <= w_vis;
            r_line   <= {1'b0, r_sy};
            r_grow   <= '0;
            r_rep    <= '0;
        end
        if (i_cmd.sum) begin
            r_addr <= r_base + 32'(r_prod_y) + 32'(r_prod_x);
        end
        if (i_cmd.emit) begin
            r_out_addr  <= r_addr;
            r_out_mask  <= w_mask;
            r_out_color <= r_color;
            r_out_size  <= r_bpp;
            r_out_last  <= o_sts.row_last;
            r_addr      <= r_addr + 32'(r_line_bytes);
            r_line      <= r_line + 13'd1;
            if (w_rep_end) begin
                r_rep  <= '0;
                r_grow <= r_grow + 3'd1;
            end else begin
                r_rep  <= r_rep + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_row_address = r_out_addr;
    assign o_pixel_mask  = r_out_mask;
    assign o_color       = r_out_color;
    assign o_pixel_size  = r_out_size;
    assign o_last_row    = r_out_last;

endmodule

/* design/scaled_glyph_row_renderer_core.sv */
// Top level of the scaled 5x7 glyph row renderer.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one item: a character code,
//   the cell's top-left pixel, a scale of 1..3 and a packed color. Lower case
//   folds to upper case; codes outside the 43-glyph font draw the unknown glyph.
//   Output channel (o_out_valid / i_out_ready) gives 7*scale row items, top row
//   first: row start address, a 5*scale pixel write mask, color, pixel size,
//   and a last-row flag on the final one. An item with scale zero gives none.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready) writes registers
//   0..4: screen width, screen height, line bytes, bytes per pixel, frame base.
//   Indexes 5..7 are ignored. Write config only while the block is idle.
// Timing:
//   The first row is valid once product, sum and output load are registered in
//   turn, the load waiting while the output register is full; then one row per
//   cycle while the receiver takes them. The next item is taken once the last
//   row sits in the output register. Each row the emit state steps the address
//   by line bytes and loads the row whenever the output register is free.
// Reset loads the register defaults (1280, 720, 5120, 4, 0) and empties the
//   output register. A stalled receiver holds the current row and freezes the
//   row sequencer; nothing is dropped.

module scaled_glyph_row_renderer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    input  logic [11:0] i_start_x,
    input  logic [11:0] i_start_y,
    input  logic [1:0]  i_scale,
    input  logic [31:0] i_pixel_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_row_address,
    output logic [14:0] o_pixel_mask,
    output logic [31:0] o_color,
    output logic [2:0]  o_pixel_size,
    output logic        o_last_row
);

    sgr_pkg::t_cmd w_cmd;
    sgr_pkg::t_sts w_sts;

    // config registers accept a write every cycle
    assign o_cfg_ready = 1'b1;

    sgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_scale    (i_scale),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sgr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_char_code   (i_char_code),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_scale       (i_scale),
        .i_pixel_value (i_pixel_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_row_address (o_row_address),
        .o_pixel_mask  (o_pixel_mask),
        .o_color       (o_color),
        .o_pixel_size  (o_pixel_size),
        .o_last_row    (o_last_row)
    );

endmodule

/* bench/tb.sv */
// Self-checking bench for scaled_glyph_row_renderer_core: directed table, then random phases.
`timescale 1ns / 1ps

module tb;

    localparam int         WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
    localparam int         SETTLE_CYCLES  = 30;    // outlasts a scale-3 item: its rows plus the setup steps
    localparam int         PHASE_ITEMS    = 56;
    localparam int         N_PHASES       = 8;
    localparam int         HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam logic [2:0] CFG_INDEX_TOP  = 3'd7;  // indexes above frame base are spare
    localparam logic [8*43-1:0] FONT_CHARS =
        " -.:/[]0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

    typedef struct packed {
        logic [7:0]  code;
        logic [11:0] x;
        logic [11:0] y;
        logic [1:0]  scale;
        logic [31:0] color;
    } t_char_item;

    typedef struct packed {
        logic [31:0] addr;
        logic [14:0] mask;
        logic [31:0] color;
        logic [2:0]  size;
        logic        last;
    } t_row;

    // one line of the directed table; first-row address and mask typed in when obvious
    typedef struct packed {
        t_char_item  item;
        logic        typed;
        logic [31:0] addr0;
        logic [14:0] mask0;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_char_code = '0;
    logic [11:0] i_start_x = '0;
    logic [11:0] i_start_y = '0;
    logic [1:0]  i_scale = '0;
    logic [31:0] i_pixel_value = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_row_address;
    logic [14:0] o_pixel_mask;
    logic [31:0] o_color;
    logic [2:0]  o_pixel_size;
    logic        o_last_row;

    // bench copy of the register file
    logic [11:0] cur_width;
    logic [11:0] cur_height;
    logic [15:0] cur_line_bytes;
    logic [2:0]  cur_pix_bytes;
    logic [31:0] cur_base;

    t_row        pending_rows[$];
    t_dir_row    char_table[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_left = 0;

    scaled_glyph_row_renderer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_char_code   (i_char_code),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_scale       (i_scale),
        .i_pixel_value (i_pixel_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_row_address (o_row_address),
        .o_pixel_mask  (o_pixel_mask),
        .o_color       (o_color),
        .o_pixel_size  (o_pixel_size),
        .o_last_row    (o_last_row)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // seven glyph rows, top row in the high bits
    function automatic logic [34:0] g7(input logic [4:0] r0, r1, r2, r3, r4, r5, r6);
        return {r0, r1, r2, r3, r4, r5, r6};
    endfunction

    function automatic logic [34:0] glyph_bits(input logic [7:0] code);
        logic [7:0] c;
        c = code;
        if (c >= "a" && c <= "z") c = c - ("a" - "A");
        case (c)
            " ": return g7(0, 0, 0, 0, 0, 0, 0);
            "-": return g7(0, 0, 0, 31, 0, 0, 0);
            ".": return g7(0, 0, 0, 0, 0, 12, 12);
            ":": return g7(0, 12, 12, 0, 12, 12, 0);
            "/": return g7(1, 2, 4, 8, 16, 0, 0);
            "[": return g7(14, 8, 8, 8, 8, 8, 14);
            "]": return g7(14, 2, 2, 2, 2, 2, 14);
            "0": return g7(14, 17, 19, 21, 25, 17, 14);
            "1": return g7(4, 12, 4, 4, 4, 4, 14);
            "2": return g7(14, 17, 1, 2, 4, 8, 31);
            "3": return g7(30, 1, 1, 14, 1, 1, 30);
            "4": return g7(2, 6, 10, 18, 31, 2, 2);
            "5": return g7(31, 16, 16, 30, 1, 1, 30);
            "6": return g7(14, 16, 16, 30, 17, 17, 14);
            "7": return g7(31, 1, 2, 4, 8, 8, 8);
            "8": return g7(14, 17, 17, 14, 17, 17, 14);
            "9": return g7(14, 17, 17, 15, 1, 1, 14);
            "A": return g7(14, 17, 17, 31, 17, 17, 17);
            "B": return g7(30, 17, 17, 30, 17, 17, 30);
            "C": return g7(14, 17, 16, 16, 16, 17, 14);
            "D": return g7(28, 18, 17, 17, 17, 18, 28);
            "E": return g7(31, 16, 16, 30, 16, 16, 31);
            "F": return g7(31, 16, 16, 30, 16, 16, 16);
            "G": return g7(14, 17, 16, 23, 17, 17, 15);
            "H": return g7(17, 17, 17, 31, 17, 17, 17);
            "I": return g7(14, 4, 4, 4, 4, 4, 14);
            "J": return g7(7, 2, 2, 2, 18, 18, 12);
            "K": return g7(17, 18, 20, 24, 20, 18, 17);
            "L": return g7(16, 16, 16, 16, 16, 16, 31);
            "M": return g7(17, 27, 21, 21, 17, 17, 17);
            "N": return g7(17, 25, 21, 19, 17, 17, 17);
            "O": return g7(14, 17, 17, 17, 17, 17, 14);
            "P": return g7(30, 17, 17, 30, 16, 16, 16);
            "Q": return g7(14, 17, 17, 17, 21, 18, 13);
            "R": return g7(30, 17, 17, 30, 20, 18, 17);
            "S": return g7(15, 16, 16, 14, 1, 1, 30);
            "T": return g7(31, 4, 4, 4, 4, 4, 4);
            "U": return g7(17, 17, 17, 17, 17, 17, 14);
            "V": return g7(17, 17, 17, 17, 17, 10, 4);
            "W": return g7(17, 17, 17, 21, 21, 21, 10);
            "X": return g7(17, 17, 10, 4, 10, 17, 17);
            "Y": return g7(17, 17, 10, 4, 4, 4, 4);
            "Z": return g7(31, 1, 2, 4, 8, 16, 31);
            default: return g7(31, 1, 2, 4, 0, 4, 0);  // unknown glyph
        endcase
    endfunction

    // Expected rows of one character: 7*scale lines, each column widened scale times.
    task automatic render_char(input t_char_item it);
        logic [34:0] dots;
        logic [4:0]  bits;
        logic [31:0] line;
        logic [31:0] x32;
        logic [31:0] lb32;
        logic [31:0] pb32;
        logic        size_ok;
        t_row        r;
        int          sc;
        int          n_rows;
        sc = int'(it.scale);
        if (sc == 0) return;  // scale zero draws nothing
        dots    = glyph_bits(it.code);
        size_ok = cur_pix_bytes >= 3'd2 && cur_pix_bytes <= 3'd4;
        x32     = 32'(it.x);
        lb32    = 32'(cur_line_bytes);
        pb32    = 32'(cur_pix_bytes);
        n_rows  = sgr_pkg::FONT_ROWS * sc;
        for (int k = 0; k < n_rows; k++) begin
            line   = 32'(it.y);
            line   = line + 32'(k);
            bits   = dots[34 - 5 * (k / sc) -: 5];
            r.addr = cur_base + line * lb32 + x32 * pb32;  // wraps at 32 bits
            r.mask = '0;
            // lines below the screen and unsupported pixel sizes keep an empty mask
            if (size_ok && line < 32'(cur_height)) begin
                for (int i = 0; i < sgr_pkg::GLYPH_COLS * sc; i++) begin
                    if (bits[4 - i / sc] && x32 + 32'(i) < 32'(cur_width)) r.mask[i] = 1'b1;
                end
            end
            r.color = it.color;
            r.size  = cur_pix_bytes;
            r.last  = (k == n_rows - 1);
            pending_rows.push_back(r);
        end
    endtask

    task automatic flag(input string fld, input logic [31:0] exp_v, input logic [31:0] act_v);
        mismatches++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, fld, exp_v, act_v);
    endtask

    task automatic check_row();
        t_row want;
        if (pending_rows.size() == 0) begin
            flag("unexpected row_address", '0, o_row_address);
            return;
        end
        want = pending_rows.pop_front();
        if (o_row_address !== want.addr)  flag("row_address", want.addr, o_row_address);
        if (o_pixel_mask  !== want.mask)  flag("pixel_mask", want.mask, o_pixel_mask);
        if (o_color       !== want.color) flag("color", want.color, o_color);
        if (o_pixel_size  !== want.size)  flag("pixel_size", want.size, o_pixel_size);
        if (o_last_row    !== want.last)  flag("last_row", want.last, o_last_row);
    endtask

    // Receiver: checks each row item taken, then picks ready for the next edge.
    // A long hold-off is counted down here once the stimulus asks for one.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) check_row();
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Presents one character and returns at the edge that takes it. Valid stays
    // high on return so the next item can follow without a gap.
    task automatic send_char(input t_char_item it);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid    <= 1'b1;
        i_char_code   <= it.code;
        i_start_x     <= it.x;
        i_start_y     <= it.y;
        i_scale       <= it.scale;
        i_pixel_value <= it.color;
        do @(posedge i_clk); while (!o_in_ready);
        render_char(it);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            sgr_pkg::CFG_SCREEN_WIDTH:  cur_width      = data[11:0];
            sgr_pkg::CFG_SCREEN_HEIGHT: cur_height     = data[11:0];
            sgr_pkg::CFG_LINE_BYTES:    cur_line_bytes = data[15:0];
            sgr_pkg::CFG_BYTES_PER_PIX: cur_pix_bytes  = data[2:0];
            sgr_pkg::CFG_FRAME_BASE:    cur_base       = data;
            default: ;  // spare index, ignored
        endcase
    endtask

    // Writes all five registers; junk in the unused upper bits must be dropped.
    task automatic apply_setting(input logic [11:0] w, input logic [11:0] h,
                                 input logic [15:0] lb, input logic [2:0] pb,
                                 input logic [31:0] base, input bit spare_too);
        logic [31:0] junk;
        if (spare_too) begin
            for (int j = sgr_pkg::CFG_FRAME_BASE + 1; j <= CFG_INDEX_TOP; j++)
                write_reg(3'(j), $urandom);
        end
        junk = $urandom;
        write_reg(sgr_pkg::CFG_SCREEN_WIDTH, {junk[31:12], w});
        junk = $urandom;
        write_reg(sgr_pkg::CFG_SCREEN_HEIGHT, {junk[31:12], h});
        junk = $urandom;
        write_reg(sgr_pkg::CFG_LINE_BYTES, {junk[31:16], lb});
        junk = $urandom;
        write_reg(sgr_pkg::CFG_BYTES_PER_PIX, {junk[31:3], pb});
        write_reg(sgr_pkg::CFG_FRAME_BASE, base);
        i_cfg_valid <= 1'b0;
    endtask

    // Drain all expected rows, then allow for a scale-zero item still in flight.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random character, biased toward font glyphs and screen edges.
    function automatic t_char_item random_char();
        t_char_item it;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            pick    = $urandom_range(42);
            it.code = FONT_CHARS[8 * pick +: 8];
        end else if (pick < 60) begin
            pick    = $urandom_range(25);
            it.code = 8'("a" + pick);
        end else begin
            it.code = 8'($urandom_range(255));
        end
        if ($urandom_range(1)) it.x = 12'($urandom_range(4095));
        else                   it.x = 12'(32'(cur_width) - $urandom_range(16));
        if ($urandom_range(1)) it.y = 12'($urandom_range(4095));
        else                   it.y = 12'(32'(cur_height) - $urandom_range(22));
        pick     = $urandom_range(19);
        it.scale = (pick == 0) ? 2'd0 : 2'(1 + pick % 3);
        it.color = $urandom;
        return it;
    endfunction

    function automatic t_dir_row mk_dir(input logic [7:0] code, input logic [11:0] x,
                                        input logic [11:0] y, input logic [1:0] scale,
                                        input logic [31:0] color, input logic typed,
                                        input logic [31:0] addr0, input logic [14:0] mask0);
        t_dir_row d;
        d.item  = {code, x, y, scale, color};
        d.typed = typed;
        d.addr0 = addr0;
        d.mask0 = mask0;
        return d;
    endfunction

    initial begin
        t_dir_row d;
        t_row     r;
        int       first;
        cur_width      = sgr_pkg::RST_SCREEN_WIDTH;
        cur_height     = sgr_pkg::RST_SCREEN_HEIGHT;
        cur_line_bytes = sgr_pkg::RST_LINE_BYTES;
        cur_pix_bytes  = sgr_pkg::RST_BYTES_PER_PIX;
        cur_base       = sgr_pkg::RST_FRAME_BASE;

        // Directed table, run on the reset register values (1280x720, 5120, 4, 0).
        // code, x, y, scale, color, typed, first-row address, first-row mask
        char_table.push_back(mk_dir("A", 0, 0, 1, 32'h0000_0000, 1, 0, 15'd14));
        char_table.push_back(mk_dir("a", 8, 0, 1, 32'hFFFF_FFFF, 1, 32, 15'd14));  // folded
        char_table.push_back(mk_dir(" ", 0, 0, 3, 32'hFFFF_FFFF, 1, 0, 15'd0));
        char_table.push_back(mk_dir(8'hFF, 0, 0, 1, 32'h1234_5678, 1, 0, 15'd31));  // unknown
        char_table.push_back(mk_dir(8'h80, 0, 1, 2, 32'hA5A5_A5A5, 1, 5120, 15'h3FF));
        char_table.push_back(mk_dir(8'h00, 0, 0, 0, 32'hDEAD_BEEF, 0, 0, 0));  // no rows
        char_table.push_back(mk_dir("H", 1278, 0, 1, 32'h1, 1, 5112, 15'd1));  // right clip
        char_table.push_back(mk_dir("A", 4095, 0, 3, 32'h0, 1, 16380, 15'd0));
        char_table.push_back(mk_dir("H", 0, 4095, 1, 32'h0, 1, 20966400, 15'd0));
        char_table.push_back(mk_dir("M", 4095, 4095, 3, 32'hFFFF_FFFF, 1, 20982780, 15'd0));
        char_table.push_back(mk_dir("8", 0, 0, 3, 32'h0, 1, 0, 15'hFF8));
        char_table.push_back(mk_dir("E", 100, 716, 1, 32'h0F0F_0F0F, 0, 0, 0));  // bottom
        char_table.push_back(mk_dir("e", 1270, 700, 3, 32'hF0F0_F0F0, 0, 0, 0));
        char_table.push_back(mk_dir("-", 20, 20, 2, 32'h5555_5555, 0, 0, 0));
        char_table.push_back(mk_dir(".", 40, 40, 1, 32'hAAAA_AAAA, 0, 0, 0));
        char_table.push_back(mk_dir(":", 60, 60, 3, 32'h0000_FFFF, 0, 0, 0));
        char_table.push_back(mk_dir("/", 80, 80, 2, 32'hFFFF_0000, 0, 0, 0));
        char_table.push_back(mk_dir("[", 100, 100, 1, 32'h0, 0, 0, 0));
        char_table.push_back(mk_dir("]", 120, 120, 3, 32'h0, 0, 0, 0));
        char_table.push_back(mk_dir("0", 140, 140, 2, 32'h0, 0, 0, 0));
        char_table.push_back(mk_dir("9", 160, 160, 1, 32'h0, 0, 0, 0));
        char_table.push_back(mk_dir("Z", 180, 180, 3, 32'h0, 0, 0, 0));
        char_table.push_back(mk_dir("z", 200, 200, 2, 32'h0, 0, 0, 0));
        char_table.push_back(mk_dir("@", 220, 220, 1, 32'h0, 0, 0, 0));
        char_table.push_back(mk_dir("Q", 1275, 719, 3, 32'h0, 0, 0, 0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (char_table[n]) begin
            d = char_table[n];
            send_char(d.item);
            // swap in the hand-worked first row where the table gives one
            if (d.typed && d.item.scale != 0) begin
                first      = pending_rows.size() - sgr_pkg::FONT_ROWS * int'(d.item.scale);
                r          = pending_rows[first];
                r.addr     = d.addr0;
                r.mask     = d.mask0;
                pending_rows[first] = r;
            end
        end

        // Random phases. Each one changes the registers while idle and picks an
        // idling pattern: none, sender gaps, receiver stalls, or both.
        for (int p = 1; p <= N_PHASES; p++) begin
            settle();
            case (p)
                1: apply_setting(4095, 4095, 16'hFFFF, 3'd4, 32'hFFFF_FFFF, 1'b1);
                2: apply_setting(1, 1, 1, 3'd2, 32'h0, 1'b0);
                3: apply_setting(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
                                 16'($urandom_range(1, 65535)), 3'd3, $urandom, 1'b0);
                // zero width and an unsupported pixel size: every mask empty
                4: apply_setting(0, 12'($urandom_range(4095)), 16'($urandom_range(65535)),
                                 3'd0, $urandom, 1'b0);
                6: apply_setting(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
                                 16'($urandom_range(1, 65535)), 3'd7, $urandom, 1'b1);
                default: apply_setting(12'($urandom_range(1, 4095)),
                                       12'($urandom_range(1, 4095)),
                                       16'($urandom_range(1, 65535)),
                                       3'($urandom_range(2, 4)), $urandom, 1'b0);
            endcase
            case ((p - 1) % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 63; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 63; end
                default: begin send_idle_pct = 33; stall_pct = 33; end
            endcase
            // back-pressure: receiver holds off while the sender keeps offering
            if (p == 5) hold_left = HOLD_CYCLES;
            for (int n = 0; n < PHASE_ITEMS; n++) send_char(random_char());
        end

        settle();
        if (mismatches == 0 && pending_rows.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
